>>> hdl/dtbl_pkg.sv
// shared constants, types and helper functions of the dual token bucket limiter
// no dependencies; compiled first

package dtbl_pkg;

	// timing and queue sizing
	localparam int TICKS_PER_SEC = 16;
	localparam int QUEUE_DEPTH   = 16;

	// field widths
	localparam int OP_RATE_W   = 20;
	localparam int BYTE_RATE_W = 32;
	localparam int TAG_W       = 8;
	localparam int BYTES_W     = 24;
	localparam int ENTRY_W     = TAG_W + BYTES_W;

	// fixed point token widths, one spare bit for the refill sum before capping
	localparam int TICK_W     = $clog2(TICKS_PER_SEC + 1);
	localparam int OP_TOK_W   = OP_RATE_W + TICK_W + 1;
	localparam int BYTE_TOK_W = BYTE_RATE_W + TICK_W + 1;
	localparam int NEED_W     = BYTES_W + TICK_W;

	// wait queue indexing
	localparam int QIDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// command queue between front and back
	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
	localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

	// register port
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	// input codes
	localparam logic OP_REQUEST = 1'b0;
	localparam logic OP_TICK    = 1'b1;
	localparam logic DIR_READ   = 1'b0;
	localparam logic DIR_WRITE  = 1'b1;

	typedef enum logic [1:0] {
		STATUS_GRANT   = 2'd0,
		STATUS_DEFER   = 2'd1,
		STATUS_RELEASE = 2'd2,
		STATUS_REJECT  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		REG_READ_OPS    = 2'd0,
		REG_READ_BYTES  = 2'd1,
		REG_WRITE_OPS   = 2'd2,
		REG_WRITE_BYTES = 2'd3
	} reg_idx_t;

	// classified command as it leaves the front
	typedef struct packed {
		logic               is_tick;
		logic               dir;
		logic [TAG_W-1:0]   tag;
		logic [BYTES_W-1:0] bytes;
		logic [NEED_W-1:0]  need;
	} cmd_t;

	// rates and bucket fill strobes, indexed by direction
	typedef struct packed {
		logic [1:0][OP_RATE_W-1:0]   op_rate;
		logic [1:0][BYTE_RATE_W-1:0] byte_rate;
		logic [1:0]                  fill;
	} cfg_t;

	// one result beat
	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic             dir;
		status_t          status;
		logic             last;
	} result_t;

	// byte tokens needed by a request
	function automatic logic [NEED_W-1:0] scale_bytes(input logic [BYTES_W-1:0] bytes);
		return NEED_W'(bytes) * NEED_W'(TICKS_PER_SEC);
	endfunction

	// op bucket burst, one second of rate
	function automatic logic [OP_TOK_W-1:0] burst_op(input logic [OP_RATE_W-1:0] rate);
		return OP_TOK_W'(rate) * OP_TOK_W'(TICKS_PER_SEC);
	endfunction

	// byte bucket burst, one second of rate
	function automatic logic [BYTE_TOK_W-1:0] burst_byte(input logic [BYTE_RATE_W-1:0] rate);
		return BYTE_TOK_W'(rate) * BYTE_TOK_W'(TICKS_PER_SEC);
	endfunction

endpackage

>>> hdl/dtbl_if.sv
// valid/ready channel interfaces for request and result beats
// depends on dtbl_pkg

interface dtbl_in_if;
	logic                        valid;
	logic                        ready;
	logic                        operation;
	logic                        direction;
	logic [dtbl_pkg::TAG_W-1:0]   request_tag;
	logic [dtbl_pkg::BYTES_W-1:0] request_bytes;

	modport source (output valid, operation, direction, request_tag, request_bytes,
		input ready);
	modport sink (input valid, operation, direction, request_tag, request_bytes,
		output ready);
endinterface

interface dtbl_out_if;
	logic                      valid;
	logic                      ready;
	logic [dtbl_pkg::TAG_W-1:0] grant_tag;
	logic                      grant_direction;
	logic [1:0]                status;
	logic                      last;

	modport source (output valid, grant_tag, grant_direction, status, last, input ready);
	modport sink (input valid, grant_tag, grant_direction, status, last, output ready);
endinterface

>>> hdl/dual_token_bucket_limiter.sv
// top level of the dual token bucket limiter; uses dtbl_pkg, dtbl_if and the dtbl_ modules
// request beat: front stage, command queue, then the idle and request states of the execution unit
// tick beat: refill, then head, scale and check per queued head examined, head only per empty queue
// tick results are held one behind so the final beat carries last
// async active-low reset zeroes rates and buckets and empties both wait queues and the command queue

module dual_token_bucket_limiter (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [dtbl_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [dtbl_pkg::APB_DATA_W-1:0] pwdata,
	output logic [dtbl_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready,
	dtbl_in_if.sink                        req,
	dtbl_out_if.source                     rsp
);
	import dtbl_pkg::*;

	cfg_t cfg;
	logic push_valid;
	logic push_ready;
	cmd_t push_cmd;
	logic cmd_valid;
	cmd_t cmd;
	logic cmd_pop;

	// rate registers
	dtbl_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// accept and classify
	dtbl_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	// decoupling queue
	dtbl_cmd_fifo u_cmd_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (cmd_valid),
		.pop_cmd    (cmd),
		.pop        (cmd_pop)
	);

	// buckets, wait queues and results
	dtbl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.rsp       (rsp)
	);

endmodule

>>> hdl/dtbl_regs.sv
// apb-style register file holding the four rate registers
// depends on dtbl_pkg; raises a bucket fill strobe the cycle after a rate write

module dtbl_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [dtbl_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [dtbl_pkg::APB_DATA_W-1:0] pwdata,
	output logic [dtbl_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready,
	output dtbl_pkg::cfg_t                 cfg
);
	import dtbl_pkg::*;

	logic [1:0][OP_RATE_W-1:0]   op_rate_q;
	logic [1:0][BYTE_RATE_W-1:0] byte_rate_q;
	logic [1:0]                  fill_q;
	logic                        wr_en;
	reg_idx_t                    idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);

	// rate registers and fill strobes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_rate_q   <= '0;
			byte_rate_q <= '0;
			fill_q      <= '0;
		end else begin
			fill_q <= '0;
			if (wr_en) begin
				unique case (idx)
					REG_READ_OPS: begin
						op_rate_q[0] <= pwdata[OP_RATE_W-1:0];
						fill_q[0]    <= 1'b1;
					end
					REG_READ_BYTES: begin
						byte_rate_q[0] <= pwdata[BYTE_RATE_W-1:0];
						fill_q[0]      <= 1'b1;
					end
					REG_WRITE_OPS: begin
						op_rate_q[1] <= pwdata[OP_RATE_W-1:0];
						fill_q[1]    <= 1'b1;
					end
					REG_WRITE_BYTES: begin
						byte_rate_q[1] <= pwdata[BYTE_RATE_W-1:0];
						fill_q[1]      <= 1'b1;
					end
				endcase
			end
		end
	end

	// read mux
	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_READ_OPS:    prdata = APB_DATA_W'(op_rate_q[0]);
			REG_READ_BYTES:  prdata = APB_DATA_W'(byte_rate_q[0]);
			REG_WRITE_OPS:   prdata = APB_DATA_W'(op_rate_q[1]);
			REG_WRITE_BYTES: prdata = APB_DATA_W'(byte_rate_q[1]);
		endcase
	end

	assign cfg.op_rate   = op_rate_q;
	assign cfg.byte_rate = byte_rate_q;
	assign cfg.fill      = fill_q;

endmodule

>>> hdl/dtbl_front.sv
// front end: accepts input beats, classifies them and scales the byte demand
// depends on dtbl_pkg and dtbl_if; feeds the command queue

module dtbl_front (
	input  logic           clk,
	input  logic           arst_n,
	dtbl_in_if.sink        req,
	output logic           push_valid,
	input  logic           push_ready,
	output dtbl_pkg::cmd_t push_cmd
);
	import dtbl_pkg::*;

	logic valid_s1;
	cmd_t cmd_s1;
	logic accept;

	// stage frees as soon as the queue takes its beat
	assign req.ready = !valid_s1 || push_ready;
	assign accept    = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	// classify and precompute the byte tokens needed
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1.is_tick <= (req.operation == OP_TICK);
			cmd_s1.dir     <= req.direction;
			cmd_s1.tag     <= req.request_tag;
			cmd_s1.bytes   <= req.request_bytes;
			cmd_s1.need    <= scale_bytes(req.request_bytes);
		end
	end

	assign push_valid = valid_s1;
	assign push_cmd   = cmd_s1;

endmodule

>>> hdl/dtbl_cmd_fifo.sv
// short command queue decoupling the front end from the execution unit
// depends on dtbl_pkg

module dtbl_cmd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  dtbl_pkg::cmd_t push_cmd,
	output logic           pop_valid,
	output dtbl_pkg::cmd_t pop_cmd,
	input  logic           pop
);
	import dtbl_pkg::*;

	cmd_t                  slot_q [CMDQ_DEPTH];
	logic [CMDQ_PTR_W-1:0] wr_ptr_q;
	logic [CMDQ_PTR_W-1:0] rd_ptr_q;
	logic [CMDQ_CNT_W-1:0] cnt_q;
	logic                  do_push;
	logic                  do_pop;

	assign push_ready = (cnt_q != CMDQ_CNT_W'(CMDQ_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;
	assign pop_cmd    = slot_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

>>> hdl/dtbl_back.sv
// execution unit: token buckets, wait queues and the result sequencer
// depends on dtbl_pkg and dtbl_if; pops classified commands from the command queue

module dtbl_back (
	input  logic           clk,
	input  logic           arst_n,
	input  dtbl_pkg::cfg_t cfg,
	input  logic           cmd_valid,
	input  dtbl_pkg::cmd_t cmd,
	output logic           cmd_pop,
	dtbl_out_if.source     rsp
);
	import dtbl_pkg::*;

	localparam int SLOT_W = QCNT_W + 1;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_REQ    = 7'b0000010,
		S_REFILL = 7'b0000100,
		S_HEAD   = 7'b0001000,
		S_SCALE  = 7'b0010000,
		S_CHECK  = 7'b0100000,
		S_FINISH = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;

	cmd_t                  cmd_q;
	logic                  dir_q;
	logic [ENTRY_W-1:0]    rd_q;
	logic [NEED_W-1:0]     need_q;
	logic                  pend_valid_q;
	result_t               pend_q;
	logic                  out_valid_q;
	result_t               out_q;

	logic [OP_TOK_W-1:0]   op_tok_q   [2];
	logic [BYTE_TOK_W-1:0] byte_tok_q [2];
	logic [QIDX_W-1:0]     head_q     [2];
	logic [QCNT_W-1:0]     cnt_q      [2];
	logic [ENTRY_W-1:0]    mem_q      [2][QUEUE_DEPTH];

	logic                  cur_dir;
	logic [NEED_W-1:0]     cur_need;
	logic                  fits;
	logic                  out_free;
	logic                  q_full;
	logic [SLOT_W-1:0]     slot_sum;
	logic [QIDX_W-1:0]     slot_idx;
	logic                  rd_en;

	logic                  take_en;
	logic                  enq;
	logic                  deq;
	logic                  refill_en;
	logic                  dir_adv;
	logic                  out_load;
	result_t               out_d;
	logic                  pend_set;
	logic                  pend_clr;

	logic [OP_TOK_W-1:0]   op_refill   [2];
	logic [BYTE_TOK_W-1:0] byte_refill [2];

	// operand selection for the bucket check
	assign cur_dir  = (state_q == S_REQ) ? cmd_q.dir : dir_q;
	assign cur_need = (state_q == S_REQ) ? cmd_q.need : need_q;
	assign fits     = (op_tok_q[cur_dir] >= OP_TOK_W'(TICKS_PER_SEC))
		&& (byte_tok_q[cur_dir] >= BYTE_TOK_W'(cur_need));
	assign out_free = !out_valid_q || rsp.ready;
	assign q_full   = (cnt_q[cur_dir] == QCNT_W'(QUEUE_DEPTH));

	// tail slot of the selected wait queue
	assign slot_sum = SLOT_W'(head_q[cur_dir]) + SLOT_W'(cnt_q[cur_dir]);
	assign slot_idx = (slot_sum >= SLOT_W'(QUEUE_DEPTH))
		? QIDX_W'(slot_sum - SLOT_W'(QUEUE_DEPTH)) : QIDX_W'(slot_sum);

	assign rd_en = (state_q == S_HEAD) && (cnt_q[dir_q] != '0);

	// refill and cap, both limiters side by side
	always_comb begin
		for (int d = 0; d < 2; d++) begin
			op_refill[d]   = op_tok_q[d] + OP_TOK_W'(cfg.op_rate[d]);
			byte_refill[d] = byte_tok_q[d] + BYTE_TOK_W'(cfg.byte_rate[d]);
			if (op_refill[d] > burst_op(cfg.op_rate[d])) begin
				op_refill[d] = burst_op(cfg.op_rate[d]);
			end
			if (byte_refill[d] > burst_byte(cfg.byte_rate[d])) begin
				byte_refill[d] = burst_byte(cfg.byte_rate[d]);
			end
		end
	end

	// sequencer
	always_comb begin
		state_d   = state_q;
		cmd_pop   = 1'b0;
		take_en   = 1'b0;
		enq       = 1'b0;
		deq       = 1'b0;
		refill_en = 1'b0;
		dir_adv   = 1'b0;
		out_load  = 1'b0;
		out_d     = pend_q;
		pend_set  = 1'b0;
		pend_clr  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					state_d = cmd.is_tick ? S_REFILL : S_REQ;
				end
			end
			S_REQ: begin
				if (out_free) begin
					out_load  = 1'b1;
					out_d.tag = cmd_q.tag;
					out_d.dir = cmd_q.dir;
					out_d.last = 1'b1;
					if (fits) begin
						take_en      = 1'b1;
						out_d.status = STATUS_GRANT;
					end else if (!q_full) begin
						enq          = 1'b1;
						out_d.status = STATUS_DEFER;
					end else begin
						out_d.status = STATUS_REJECT;
					end
					state_d = S_IDLE;
				end
			end
			S_REFILL: begin
				refill_en = 1'b1;
				state_d   = S_HEAD;
			end
			S_HEAD: begin
				if (cnt_q[dir_q] != '0) begin
					state_d = S_SCALE;
				end else if (dir_q == DIR_READ) begin
					dir_adv = 1'b1;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_SCALE: begin
				state_d = S_CHECK;
			end
			S_CHECK: begin
				if (!fits) begin
					if (dir_q == DIR_READ) begin
						dir_adv = 1'b1;
						state_d = S_HEAD;
					end else begin
						state_d = S_FINISH;
					end
				end else if (!pend_valid_q || out_free) begin
					take_en  = 1'b1;
					deq      = 1'b1;
					pend_set = 1'b1;
					if (pend_valid_q) begin
						out_load   = 1'b1;
						out_d.last = 1'b0;
					end
					state_d = S_HEAD;
				end
			end
			S_FINISH: begin
				if (!pend_valid_q) begin
					state_d = S_IDLE;
				end else if (out_free) begin
					out_load   = 1'b1;
					out_d.last = 1'b1;
					pend_clr   = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			dir_q        <= DIR_READ;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_REFILL) begin
				dir_q <= DIR_READ;
			end else if (dir_adv) begin
				dir_q <= DIR_WRITE;
			end
			if (pend_set) begin
				pend_valid_q <= 1'b1;
			end else if (pend_clr) begin
				pend_valid_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// token buckets: fill on a rate write, refill on a tick, take on a grant or a release
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < 2; d++) begin
				op_tok_q[d]   <= '0;
				byte_tok_q[d] <= '0;
			end
		end else begin
			for (int d = 0; d < 2; d++) begin
				priority if (cfg.fill[d]) begin
					op_tok_q[d]   <= burst_op(cfg.op_rate[d]);
					byte_tok_q[d] <= burst_byte(cfg.byte_rate[d]);
				end else if (refill_en) begin
					op_tok_q[d]   <= op_refill[d];
					byte_tok_q[d] <= byte_refill[d];
				end else if (take_en && (cur_dir == 1'(d))) begin
					op_tok_q[d]   <= op_tok_q[d] - OP_TOK_W'(TICKS_PER_SEC);
					byte_tok_q[d] <= byte_tok_q[d] - BYTE_TOK_W'(cur_need);
				end
			end
		end
	end

	// wait queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < 2; d++) begin
				head_q[d] <= '0;
				cnt_q[d]  <= '0;
			end
		end else begin
			for (int d = 0; d < 2; d++) begin
				if (enq && (cur_dir == 1'(d))) begin
					cnt_q[d] <= cnt_q[d] + 1'b1;
				end else if (deq && (dir_q == 1'(d))) begin
					cnt_q[d]  <= cnt_q[d] - 1'b1;
					head_q[d] <= (head_q[d] == QIDX_W'(QUEUE_DEPTH - 1))
						? '0 : head_q[d] + 1'b1;
				end
			end
		end
	end

	// wait queue storage, registered read of the head entry
	always_ff @(posedge clk) begin
		if (enq) begin
			mem_q[cur_dir][slot_idx] <= {cmd_q.tag, cmd_q.bytes};
		end
		if (rd_en) begin
			rd_q <= mem_q[dir_q][head_q[dir_q]];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd;
		end
		if (state_q == S_SCALE) begin
			need_q <= scale_bytes(rd_q[BYTES_W-1:0]);
		end
		if (pend_set) begin
			pend_q.tag    <= rd_q[ENTRY_W-1 -: TAG_W];
			pend_q.dir    <= dir_q;
			pend_q.status <= STATUS_RELEASE;
			pend_q.last   <= 1'b0;
		end
		if (out_load) begin
			out_q <= out_d;
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.grant_tag       = out_q.tag;
	assign rsp.grant_direction = out_q.dir;
	assign rsp.status          = out_q.status;
	assign rsp.last            = out_q.last;

endmodule

>>> hdl/dtbl_checker.sv
// port-level checks of the dual token bucket limiter, attached by bind
// depends on dtbl_pkg and the top level dual_token_bucket_limiter

module dtbl_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      req_valid,
	input logic                      req_ready,
	input logic                      req_operation,
	input logic                      rsp_valid,
	input logic                      rsp_ready,
	input logic [dtbl_pkg::TAG_W-1:0] rsp_grant_tag,
	input logic                      rsp_grant_direction,
	input logic [1:0]                rsp_status,
	input logic                      rsp_last
);
	import dtbl_pkg::*;

	logic [3:0] open_req_q;
	logic       req_in;
	logic       req_out;

	assign req_in  = req_valid && req_ready && (req_operation == OP_REQUEST);
	assign req_out = rsp_valid && rsp_ready && (rsp_status != STATUS_RELEASE);

	// requests accepted but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_req_q <= '0;
		end else if (req_in && !req_out) begin
			open_req_q <= open_req_q + 1'b1;
		end else if (req_out && !req_in) begin
			open_req_q <= open_req_q - 1'b1;
		end
	end

	// a stalled result beat stays offered
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result beat withdrawn while stalled");

	// a stalled result beat keeps its payload
	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_grant_tag) && $stable(rsp_grant_direction)
			&& $stable(rsp_status) && $stable(rsp_last))
		else $error("result payload changed while stalled");

	// a request answer is always the only beat of its input
	a_answer_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status != STATUS_RELEASE) |-> rsp_last)
		else $error("request answer without last");

	// no answer without an outstanding request
	a_answer_owed: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status != STATUS_RELEASE) |-> (open_req_q != '0))
		else $error("request answer with no request outstanding");

endmodule

bind dual_token_bucket_limiter dtbl_checker u_dtbl_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.req_valid           (req.valid),
	.req_ready           (req.ready),
	.req_operation       (req.operation),
	.rsp_valid           (rsp.valid),
	.rsp_ready           (rsp.ready),
	.rsp_grant_tag       (rsp.grant_tag),
	.rsp_grant_direction (rsp.grant_direction),
	.rsp_status          (rsp.status),
	.rsp_last            (rsp.last)
);

>>> bench/tb.sv
`timescale 1ns / 1ps
// self-checking bench for dual_token_bucket_limiter: random request and tick beats, rate changes
// over the register port, and a bucket-and-queue predictor checked against every result beat
// depends on dtbl_pkg, dtbl_if and the limiter rtl

module tb;
	import dtbl_pkg::*;

	localparam int SETTLE_CYCLES = 200;
	localparam int HOLD_CYCLES   = 400;
	localparam int HOLD_AFTER    = 120;
	localparam int RUN_LIMIT     = 500000;
	localparam int PHASES        = 6;
	localparam int PHASE_BEATS   = 65;

	typedef logic [OP_TOK_W-1:0]   op_units_t;
	typedef logic [BYTE_TOK_W-1:0] byte_units_t;

	typedef struct packed {
		logic               op;
		logic               dir;
		logic [TAG_W-1:0]   tag;
		logic [BYTES_W-1:0] bytes;
	} beat_t;

	typedef struct packed {
		logic [TAG_W-1:0]   tag;
		logic [BYTES_W-1:0] bytes;
	} waiter_t;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	dtbl_in_if  req_ch ();
	dtbl_out_if rsp_ch ();

	dual_token_bucket_limiter u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req     (req_ch),
		.rsp     (rsp_ch)
	);

	// predicted limiter state, index 0 read, 1 write
	logic [OP_RATE_W-1:0]   ops_per_sec   [2];
	logic [BYTE_RATE_W-1:0] bytes_per_sec [2];
	op_units_t              op_units      [2];
	byte_units_t            byte_units    [2];
	waiter_t                wait_ring     [2][QUEUE_DEPTH];
	int unsigned            wait_head     [2];
	int unsigned            wait_count    [2];

	beat_t   beats_pending [$];
	result_t grants_due [$];
	beat_t   next_beat;
	result_t grant_want;

	int fails = 0;
	int idle_pct;
	int gap_left;
	int stall_left;
	int hold_left;
	bit hold_done;
	int beats_in;
	int cycles = 0;

	// gap lengths: mostly short, a few long
	function automatic int pick_gap();
		int r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic op_units_t op_burst(int d);
		return op_units_t'(ops_per_sec[d]) * op_units_t'(TICKS_PER_SEC);
	endfunction

	function automatic byte_units_t byte_burst(int d);
		return byte_units_t'(bytes_per_sec[d]) * byte_units_t'(TICKS_PER_SEC);
	endfunction

	function automatic bit bucket_fits(int d, logic [BYTES_W-1:0] b);
		return op_units[d] >= op_units_t'(TICKS_PER_SEC) &&
			byte_units[d] >= byte_units_t'(b) * byte_units_t'(TICKS_PER_SEC);
	endfunction

	function automatic void bucket_take(int d, logic [BYTES_W-1:0] b);
		op_units[d]   = op_units[d] - op_units_t'(TICKS_PER_SEC);
		byte_units[d] = byte_units[d] - byte_units_t'(b) * byte_units_t'(TICKS_PER_SEC);
	endfunction

	// register write: masked rate, both buckets of that limiter filled to burst
	function automatic void set_rate(reg_idx_t idx, logic [31:0] value);
		int d = (idx == REG_WRITE_OPS || idx == REG_WRITE_BYTES) ? 1 : 0;
		if (idx == REG_READ_OPS || idx == REG_WRITE_OPS)
			ops_per_sec[d] = value[OP_RATE_W-1:0];
		else
			bytes_per_sec[d] = value;
		op_units[d]   = op_burst(d);
		byte_units[d] = byte_burst(d);
	endfunction

	// expected result beats of one accepted beat
	function automatic void predict_grants(logic op, logic dir, logic [TAG_W-1:0] tag,
		logic [BYTES_W-1:0] bytes);
		int      d;
		status_t st;
		result_t held;
		bit      have_held;
		waiter_t w;
		have_held = 1'b0;
		if (op == OP_REQUEST) begin
			d = int'(dir);
			if (bucket_fits(d, bytes)) begin
				bucket_take(d, bytes);
				st = STATUS_GRANT;
			end else if (wait_count[d] < QUEUE_DEPTH) begin
				wait_ring[d][(wait_head[d] + wait_count[d]) % QUEUE_DEPTH] = '{tag, bytes};
				wait_count[d]++;
				st = STATUS_DEFER;
			end else begin
				st = STATUS_REJECT;
			end
			grants_due.push_back('{tag, dir, st, 1'b1});
			return;
		end
		// tick: refill and cap, then drain heads in order, read first; last goes on the final one
		for (d = 0; d < 2; d++) begin
			op_units[d]   = op_units[d] + op_units_t'(ops_per_sec[d]);
			byte_units[d] = byte_units[d] + byte_units_t'(bytes_per_sec[d]);
			if (op_units[d] > op_burst(d))
				op_units[d] = op_burst(d);
			if (byte_units[d] > byte_burst(d))
				byte_units[d] = byte_burst(d);
			while (wait_count[d] > 0) begin
				w = wait_ring[d][wait_head[d]];
				if (!bucket_fits(d, w.bytes))
					break;
				bucket_take(d, w.bytes);
				if (have_held)
					grants_due.push_back(held);
				held      = '{w.tag, 1'(d), STATUS_RELEASE, 1'b0};
				have_held = 1'b1;
				wait_head[d] = (wait_head[d] + 1) % QUEUE_DEPTH;
				wait_count[d]--;
			end
		end
		if (have_held) begin
			held.last = 1'b1;
			grants_due.push_back(held);
		end
	endfunction

	function automatic beat_t random_beat();
		beat_t b;
		int    r;
		b.op  = ($urandom_range(0, 99) < 30) ? OP_TICK : OP_REQUEST;
		b.dir = 1'($urandom_range(0, 1));
		b.tag = TAG_W'($urandom_range(0, 255));
		r = $urandom_range(0, 99);
		if (r < 10)
			b.bytes = '0;
		else if (r < 80)
			b.bytes = BYTES_W'($urandom_range(1, 255));
		else if (r < 95)
			b.bytes = BYTES_W'($urandom_range(256, 4095));
		else
			b.bytes = BYTES_W'($urandom);
		return b;
	endfunction

	// mostly small rates so that requests queue up and ticks release them
	function automatic logic [31:0] random_rate(bit is_ops);
		int r = $urandom_range(0, 99);
		if (r < 10)
			return 32'd0;
		if (r < 20)
			return is_ops ? 32'hF_FFFF : 32'hFFFF_FFFF;
		if (r < 30)
			return $urandom;
		return is_ops ? $urandom_range(1, 48) : $urandom_range(64, 8192);
	endfunction

	// register write: setup beat then access beat
	task automatic write_rate(input reg_idx_t idx, input logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_ADDR_W'({idx, 2'b00});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		set_rate(idx, value);
	endtask

	task automatic write_all_rates(input logic [31:0] rd_ops, input logic [31:0] rd_bytes,
		input logic [31:0] wr_ops, input logic [31:0] wr_bytes);
		write_rate(REG_READ_OPS, rd_ops);
		write_rate(REG_READ_BYTES, rd_bytes);
		write_rate(REG_WRITE_OPS, wr_ops);
		write_rate(REG_WRITE_BYTES, wr_bytes);
	endtask

	// wait for all beats sent and all results back, then let a silent tick finish
	task automatic settle();
		do
			@(negedge clk);
		while (beats_pending.size() != 0 || req_ch.valid || grants_due.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == RUN_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	// request driver, fed from beats_pending; prediction happens on acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid         <= 1'b0;
			req_ch.operation     <= 1'b0;
			req_ch.direction     <= 1'b0;
			req_ch.request_tag   <= '0;
			req_ch.request_bytes <= '0;
			gap_left             <= 0;
			beats_in             <= 0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				predict_grants(req_ch.operation, req_ch.direction, req_ch.request_tag,
					req_ch.request_bytes);
				beats_in <= beats_in + 1;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (gap_left > 0) begin
					gap_left     <= gap_left - 1;
					req_ch.valid <= 1'b0;
				end else if (beats_pending.size() == 0) begin
					req_ch.valid <= 1'b0;
				end else if ($urandom_range(0, 99) < idle_pct) begin
					gap_left     <= pick_gap() - 1;
					req_ch.valid <= 1'b0;
				end else begin
					next_beat = beats_pending.pop_front();
					req_ch.valid         <= 1'b1;
					req_ch.operation     <= next_beat.op;
					req_ch.direction     <= next_beat.dir;
					req_ch.request_tag   <= next_beat.tag;
					req_ch.request_bytes <= next_beat.bytes;
				end
			end
		end
	end

	// result ready: one long hold-off to back the block up, random stalls otherwise
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall_left   <= 0;
			hold_left    <= 0;
			hold_done    <= 1'b0;
		end else if (!hold_done && beats_in >= HOLD_AFTER) begin
			hold_done    <= 1'b1;
			hold_left    <= HOLD_CYCLES;
			rsp_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left    <= hold_left - 1;
			rsp_ch.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left   <= stall_left - 1;
			rsp_ch.ready <= 1'b0;
		end else if ($urandom_range(0, 99) < idle_pct) begin
			stall_left   <= pick_gap() - 1;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	// result checker against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (grants_due.size() == 0) begin
				$display("%0t: unexpected result tag %0d dir %0d status %0d last %0d", $time,
					rsp_ch.grant_tag, rsp_ch.grant_direction, rsp_ch.status, rsp_ch.last);
				fails++;
			end else begin
				grant_want = grants_due.pop_front();
				if (rsp_ch.grant_tag !== grant_want.tag) begin
					$display("%0t: grant_tag expected %0d got %0d", $time, grant_want.tag,
						rsp_ch.grant_tag);
					fails++;
				end
				if (rsp_ch.grant_direction !== grant_want.dir) begin
					$display("%0t: grant_direction expected %0d got %0d", $time,
						grant_want.dir, rsp_ch.grant_direction);
					fails++;
				end
				if (rsp_ch.status !== grant_want.status) begin
					$display("%0t: status expected %0d got %0d", $time, grant_want.status,
						rsp_ch.status);
					fails++;
				end
				if (rsp_ch.last !== grant_want.last) begin
					$display("%0t: last expected %0d got %0d", $time, grant_want.last,
						rsp_ch.last);
					fails++;
				end
			end
		end
	end

	// stimulus and phase sequencing
	initial begin
		arst_n   = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		idle_pct = 0;
		for (int d = 0; d < 2; d++) begin
			ops_per_sec[d]   = '0;
			bytes_per_sec[d] = '0;
			op_units[d]      = '0;
			byte_units[d]    = '0;
			wait_head[d]     = 0;
			wait_count[d]    = 0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// all rates zero after reset: nothing fits, a tick releases nothing
		beats_pending.push_back('{OP_REQUEST, DIR_READ, 8'h00, 24'h00_0000});
		beats_pending.push_back('{OP_REQUEST, DIR_READ, 8'hFF, 24'hFF_FFFF});
		beats_pending.push_back('{OP_REQUEST, DIR_WRITE, 8'hA5, 24'h00_0000});
		beats_pending.push_back('{OP_TICK, DIR_WRITE, 8'h3C, 24'hFF_FFFF});
		settle();

		// read at full rate, write one op per second with no byte budget
		write_all_rates(32'hF_FFFF, 32'hFFFF_FFFF, 32'd1, 32'd0);
		@(negedge clk);
		beats_pending.push_back('{OP_TICK, DIR_READ, 8'h00, 24'h00_0000});
		beats_pending.push_back('{OP_REQUEST, DIR_WRITE, 8'h01, 24'h00_0000});
		beats_pending.push_back('{OP_REQUEST, DIR_WRITE, 8'h02, 24'h00_0001});
		beats_pending.push_back('{OP_REQUEST, DIR_READ, 8'h5A, 24'hFF_FFFF});
		beats_pending.push_back('{OP_TICK, DIR_READ, 8'hFF, 24'h00_0000});
		// fill the write queue until it rejects
		for (int i = 0; i < 15; i++)
			beats_pending.push_back('{OP_REQUEST, DIR_WRITE, 8'(8'h10 + i), 24'h00_0000});
		settle();

		// random phases with varied rates and idling
		for (int p = 0; p < PHASES; p++) begin
			write_all_rates(random_rate(1'b1), random_rate(1'b0), random_rate(1'b1),
				random_rate(1'b0));
			@(negedge clk);
			idle_pct = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 30 : 60);
			for (int i = 0; i < PHASE_BEATS; i++)
				beats_pending.push_back(random_beat());
			settle();
		end

		// full rates drain what is left in the queues
		write_all_rates(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		@(negedge clk);
		idle_pct = 20;
		for (int i = 0; i < 20; i++)
			beats_pending.push_back(random_beat());
		beats_pending.push_back('{OP_TICK, DIR_READ, 8'h00, 24'h00_0000});
		settle();

		if (fails == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule

>>> filelist.f
hdl/dtbl_pkg.sv
hdl/dtbl_if.sv
hdl/dtbl_regs.sv
hdl/dtbl_front.sv
hdl/dtbl_cmd_fifo.sv
hdl/dtbl_back.sv
hdl/dual_token_bucket_limiter.sv
hdl/dtbl_checker.sv
bench/tb.sv
